FILE: rtl/irie_pkg.sv
`timescale 1ns / 1ps

package irie_pkg;

    // Opcodes that follow the index prefix.
    localparam logic [7:0] OP_ADD_IX_BC  = 8'h09;
    localparam logic [7:0] OP_ADD_IX_DE  = 8'h19;
    localparam logic [7:0] OP_LD_IX_NN   = 8'h21;
    localparam logic [7:0] OP_ST_NN_IX   = 8'h22;
    localparam logic [7:0] OP_INC_IX     = 8'h23;
    localparam logic [7:0] OP_ADD_IX_IX  = 8'h29;
    localparam logic [7:0] OP_LD_IX_MNN  = 8'h2a;
    localparam logic [7:0] OP_DEC_IX     = 8'h2b;
    localparam logic [7:0] OP_INC_MEM    = 8'h34;
    localparam logic [7:0] OP_DEC_MEM    = 8'h35;
    localparam logic [7:0] OP_ST_MEM_N   = 8'h36;
    localparam logic [7:0] OP_ADD_IX_SP  = 8'h39;
    localparam logic [7:0] OP_LD_B_MEM   = 8'h46;
    localparam logic [7:0] OP_LD_C_MEM   = 8'h4e;
    localparam logic [7:0] OP_LD_D_MEM   = 8'h56;
    localparam logic [7:0] OP_LD_E_MEM   = 8'h5e;
    localparam logic [7:0] OP_LD_H_MEM   = 8'h66;
    localparam logic [7:0] OP_LD_L_MEM   = 8'h6e;
    localparam logic [7:0] OP_ST_MEM_B   = 8'h70;
    localparam logic [7:0] OP_ST_MEM_C   = 8'h71;
    localparam logic [7:0] OP_ST_MEM_D   = 8'h72;
    localparam logic [7:0] OP_ST_MEM_E   = 8'h73;
    localparam logic [7:0] OP_ST_MEM_H   = 8'h74;
    localparam logic [7:0] OP_ST_MEM_L   = 8'h75;
    localparam logic [7:0] OP_ST_MEM_A   = 8'h77;
    localparam logic [7:0] OP_LD_A_MEM   = 8'h7e;
    localparam logic [7:0] OP_ADD_A_MEM  = 8'h86;
    localparam logic [7:0] OP_ADC_A_MEM  = 8'h8e;
    localparam logic [7:0] OP_SUB_A_MEM  = 8'h96;
    localparam logic [7:0] OP_SBC_A_MEM  = 8'h9e;
    localparam logic [7:0] OP_AND_A_MEM  = 8'ha6;
    localparam logic [7:0] OP_XOR_A_MEM  = 8'hae;
    localparam logic [7:0] OP_OR_A_MEM   = 8'hb6;
    localparam logic [7:0] OP_CP_A_MEM   = 8'hbe;
    localparam logic [7:0] OP_BIT_ESC    = 8'hcb;
    localparam logic [7:0] OP_POP_IX     = 8'he1;
    localparam logic [7:0] OP_EX_SP_IX   = 8'he3;
    localparam logic [7:0] OP_PUSH_IX    = 8'he5;
    localparam logic [7:0] OP_JP_IX      = 8'he9;
    localparam logic [7:0] OP_LD_SP_IX   = 8'hf9;

    // Status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_ILLEGAL = 2'd1;
    localparam logic [1:0] ST_ESCAPE  = 2'd2;

    typedef struct packed {
        logic [7:0]  acc;
        logic [7:0]  flags;
        logic [15:0] index;
    } t_cpu_state;

    typedef struct packed {
        logic [15:0] eff_address;
        logic        mem_write;
        logic [7:0]  write_byte;
        logic [15:0] word_result;
        logic [7:0]  load_byte;
        logic [1:0]  status;
        logic [4:0]  t_states;
    } t_exec_res;

endpackage

FILE: rtl/irie_exec.sv
`timescale 1ns / 1ps

module irie_exec (
    input  logic [7:0]           i_kind,
    input  logic signed [7:0]    i_displacement,
    input  logic [7:0]           i_mem_byte,
    input  logic [15:0]          i_word_in,
    input  logic [7:0]           i_reg_byte,
    input  irie_pkg::t_cpu_state i_state,
    output irie_pkg::t_cpu_state o_state,
    output irie_pkg::t_exec_res  o_res
);

    logic [7:0]  a;
    logic [7:0]  f;
    logic [15:0] ix;
    logic [7:0]  mb;
    logic        cin;
    logic [8:0]  add_sum;
    logic [4:0]  add_half;
    logic [7:0]  sub_r;
    logic        sub_h;
    logic        sub_c;
    logic [7:0]  add_flags;
    logic [7:0]  sub_flags;
    logic [15:0] add16_y;
    logic [16:0] add16_sum;
    logic [12:0] add16_half;
    logic [7:0]  add16_flags;
    logic [7:0]  inc_r;
    logic [7:0]  dec_r;
    logic [7:0]  and_r;
    logic [7:0]  xor_r;
    logic [7:0]  or_r;
    logic [15:0] ea;

    assign a  = i_state.acc;
    assign f  = i_state.flags;
    assign ix = i_state.index;
    assign mb = i_mem_byte;

    // Carry in only for the with-carry forms.
    assign cin = f[0] & ((i_kind == irie_pkg::OP_ADC_A_MEM) ||
                         (i_kind == irie_pkg::OP_SBC_A_MEM));

    assign add_sum  = {1'b0, a} + {1'b0, mb} + {8'd0, cin};
    assign add_half = {1'b0, a[3:0]} + {1'b0, mb[3:0]} + {4'd0, cin};
    assign add_flags = {add_sum[7], add_sum[7:0] == 8'd0, f[5], add_half[4], f[3],
                        ((a[7] ^ add_sum[7]) & (mb[7] ^ add_sum[7])), 1'b0, add_sum[8]};

    assign sub_r = a - mb - {7'd0, cin};
    assign sub_h = ({1'b0, mb[3:0]} + {4'd0, cin}) > {1'b0, a[3:0]};
    assign sub_c = ({1'b0, mb} + {8'd0, cin}) > {1'b0, a};
    assign sub_flags = {sub_r[7], sub_r == 8'd0, f[5], sub_h, f[3],
                        ((a[7] ^ mb[7]) & (a[7] ^ sub_r[7])), 1'b1, sub_c};

    assign add16_y    = (i_kind == irie_pkg::OP_ADD_IX_IX) ? ix : i_word_in;
    assign add16_sum  = {1'b0, ix} + {1'b0, add16_y};
    assign add16_half = {1'b0, ix[11:0]} + {1'b0, add16_y[11:0]};
    assign add16_flags = {f[7:5], add16_half[12], f[3:2], 1'b0, add16_sum[16]};

    assign inc_r = mb + 8'd1;
    assign dec_r = mb - 8'd1;
    assign and_r = a & mb;
    assign xor_r = a ^ mb;
    assign or_r  = a | mb;

    assign ea = ix + {{8{i_displacement[7]}}, i_displacement};

    always_comb begin
        o_state = i_state;
        o_res   = '0;
        o_res.eff_address = ea;
        o_res.status      = irie_pkg::ST_OK;
        case (i_kind)
            irie_pkg::OP_ADD_IX_BC, irie_pkg::OP_ADD_IX_DE,
            irie_pkg::OP_ADD_IX_SP, irie_pkg::OP_ADD_IX_IX: begin
                o_state.index  = add16_sum[15:0];
                o_state.flags  = add16_flags;
                o_res.t_states = 5'd15;
            end
            irie_pkg::OP_LD_IX_NN, irie_pkg::OP_POP_IX: begin
                o_state.index  = i_word_in;
                o_res.t_states = 5'd14;
            end
            irie_pkg::OP_LD_IX_MNN: begin
                o_state.index  = i_word_in;
                o_res.t_states = 5'd20;
            end
            irie_pkg::OP_ST_NN_IX: begin
                o_res.word_result = ix;
                o_res.t_states    = 5'd20;
            end
            irie_pkg::OP_INC_IX: begin
                o_state.index  = ix + 16'd1;
                o_res.t_states = 5'd10;
            end
            irie_pkg::OP_DEC_IX: begin
                o_state.index  = ix - 16'd1;
                o_res.t_states = 5'd10;
            end
            irie_pkg::OP_INC_MEM: begin
                o_state.flags = {inc_r[7], inc_r == 8'd0, f[5], mb[3:0] == 4'hf, f[3],
                                 inc_r == 8'h80, 1'b0, f[0]};
                o_res.mem_write  = 1'b1;
                o_res.write_byte = inc_r;
                o_res.t_states   = 5'd23;
            end
            irie_pkg::OP_DEC_MEM: begin
                o_state.flags = {dec_r[7], dec_r == 8'd0, f[5], mb[3:0] == 4'h0, f[3],
                                 dec_r == 8'h7f, 1'b1, f[0]};
                o_res.mem_write  = 1'b1;
                o_res.write_byte = dec_r;
                o_res.t_states   = 5'd23;
            end
            irie_pkg::OP_ST_MEM_N, irie_pkg::OP_ST_MEM_B, irie_pkg::OP_ST_MEM_C,
            irie_pkg::OP_ST_MEM_D, irie_pkg::OP_ST_MEM_E, irie_pkg::OP_ST_MEM_H,
            irie_pkg::OP_ST_MEM_L: begin
                o_res.mem_write  = 1'b1;
                o_res.write_byte = i_reg_byte;
                o_res.t_states   = 5'd19;
            end
            irie_pkg::OP_ST_MEM_A: begin
                o_res.mem_write  = 1'b1;
                o_res.write_byte = a;
                o_res.t_states   = 5'd19;
            end
            irie_pkg::OP_LD_B_MEM, irie_pkg::OP_LD_C_MEM, irie_pkg::OP_LD_D_MEM,
            irie_pkg::OP_LD_E_MEM, irie_pkg::OP_LD_H_MEM, irie_pkg::OP_LD_L_MEM: begin
                o_res.load_byte = mb;
                o_res.t_states  = 5'd19;
            end
            irie_pkg::OP_LD_A_MEM: begin
                o_res.load_byte = mb;
                o_state.acc     = mb;
                o_res.t_states  = 5'd19;
            end
            irie_pkg::OP_ADD_A_MEM, irie_pkg::OP_ADC_A_MEM: begin
                o_state.acc    = add_sum[7:0];
                o_state.flags  = add_flags;
                o_res.t_states = 5'd19;
            end
            irie_pkg::OP_SUB_A_MEM, irie_pkg::OP_SBC_A_MEM: begin
                o_state.acc    = sub_r;
                o_state.flags  = sub_flags;
                o_res.t_states = 5'd19;
            end
            irie_pkg::OP_CP_A_MEM: begin
                o_state.flags  = sub_flags;
                o_res.t_states = 5'd19;
            end
            irie_pkg::OP_AND_A_MEM: begin
                o_state.acc    = and_r;
                o_state.flags  = {and_r[7], and_r == 8'd0, f[5], 1'b1, f[3], ~^and_r,
                                  2'b00};
                o_res.t_states = 5'd19;
            end
            irie_pkg::OP_XOR_A_MEM: begin
                o_state.acc    = xor_r;
                o_state.flags  = {xor_r[7], xor_r == 8'd0, f[5], 1'b0, f[3], ~^xor_r,
                                  2'b00};
                o_res.t_states = 5'd19;
            end
            irie_pkg::OP_OR_A_MEM: begin
                o_state.acc    = or_r;
                o_state.flags  = {or_r[7], or_r == 8'd0, f[5], 1'b0, f[3], ~^or_r,
                                  2'b00};
                o_res.t_states = 5'd19;
            end
            irie_pkg::OP_PUSH_IX: begin
                o_res.word_result = ix;
                o_res.t_states    = 5'd15;
            end
            irie_pkg::OP_EX_SP_IX: begin
                o_res.word_result = ix;
                o_state.index     = i_word_in;
                o_res.t_states    = 5'd23;
            end
            irie_pkg::OP_JP_IX: begin
                o_res.word_result = ix;
                o_res.t_states    = 5'd8;
            end
            irie_pkg::OP_LD_SP_IX: begin
                o_res.word_result = ix;
                o_res.t_states    = 5'd10;
            end
            irie_pkg::OP_BIT_ESC: begin
                o_res        = '0;
                o_res.status = irie_pkg::ST_ESCAPE;
            end
            default: begin
                o_res        = '0;
                o_res.status = irie_pkg::ST_ILLEGAL;
            end
        endcase
    end

endmodule

FILE: rtl/indexed_register_instruction_executor_top.sv
`timescale 1ns / 1ps

// Index-prefixed instruction executor.
// Input stream: one transfer per instruction. tuser carries the opcode byte that
// follows the prefix; tdata carries the displacement, the memory operand byte,
// the word operand and the source register byte.
// Output stream: one transfer per instruction with the effective address, the
// memory write request, the loaded byte, the word result, the new accumulator,
// flags and index register, and the clock count; tuser carries the status.
// An instruction is held in the input register and its result in the output
// register. Throughput is one instruction per cycle while the receiver keeps up,
// set by the single execute stage that updates the accumulator, flags and
// index register as the instruction moves from the input to the output register.
// When the receiver stalls, the finished result holds in the output register
// and one further instruction can still be taken into the input register;
// after that, o_s_axis_tready drops until the output transfer completes.
// Synchronous reset clears the accumulator, flags and index register to zero
// and empties both registers.

module indexed_register_instruction_executor_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // displacement[7:0], mem_byte[15:8], word_in[31:16], reg_byte[39:32]
    input  logic [39:0] i_s_axis_tdata,
    // kind[7:0]
    input  logic [7:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // eff_address[15:0], mem_write[16], write_byte[24:17], word_result[40:25],
    // load_byte[48:41], acc_out[56:49], flags_out[64:57], index_out[80:65],
    // t_states[85:81], zero fill [87:86]
    output logic [87:0] o_m_axis_tdata,
    // status[1:0]
    output logic [1:0]  o_m_axis_tuser
);

    logic                 r_in_valid;
    logic [7:0]           r_kind;
    logic signed [7:0]    r_displacement;
    logic [7:0]           r_mem_byte;
    logic [15:0]          r_word_in;
    logic [7:0]           r_reg_byte;

    irie_pkg::t_cpu_state r_state;
    irie_pkg::t_cpu_state n_state;
    irie_pkg::t_exec_res  n_res;

    logic                 r_out_valid;
    irie_pkg::t_exec_res  r_res;
    irie_pkg::t_cpu_state r_out_state;

    logic                 advance;
    logic                 in_xfer;

    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;
    assign in_xfer         = i_s_axis_tvalid && o_s_axis_tready;

    irie_exec u_exec (
        .i_kind         (r_kind),
        .i_displacement (r_displacement),
        .i_mem_byte     (r_mem_byte),
        .i_word_in      (r_word_in),
        .i_reg_byte     (r_reg_byte),
        .i_state        (r_state),
        .o_state        (n_state),
        .o_res          (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (in_xfer) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_kind         <= i_s_axis_tuser;
            r_displacement <= i_s_axis_tdata[7:0];
            r_mem_byte     <= i_s_axis_tdata[15:8];
            r_word_in      <= i_s_axis_tdata[31:16];
            r_reg_byte     <= i_s_axis_tdata[39:32];
        end
        if (advance) begin
            r_res       <= n_res;
            r_out_state <= n_state;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_res.status;
    assign o_m_axis_tdata  = {2'b00,
                              r_res.t_states,
                              r_out_state.index,
                              r_out_state.flags,
                              r_out_state.acc,
                              r_res.load_byte,
                              r_res.word_result,
                              r_res.write_byte,
                              r_res.mem_write,
                              r_res.eff_address};

    // A trapped instruction leaves the architectural state untouched.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && n_res.status != irie_pkg::ST_OK) |=> (r_state == $past(r_state)))
        else $error("trapped instruction changed the register state");

    // The clock count is zero exactly when the instruction trapped.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_res.status != irie_pkg::ST_OK) == (r_res.t_states == 5'd0)))
        else $error("clock count does not match status");

    // A trap never requests a memory write.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.status != irie_pkg::ST_OK) |->
        (!r_res.mem_write && r_res.write_byte == 8'd0 && r_res.eff_address == 16'd0))
        else $error("trapped instruction drives a memory write");

    // The presented register values are the ones the next instruction starts from.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> (r_out_state == r_state))
        else $error("output register state differs from working state");

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam logic [7:0] FLAG_S   = 8'h80;
    localparam logic [7:0] FLAG_Z   = 8'h40;
    localparam logic [7:0] FLAG_H   = 8'h10;
    localparam logic [7:0] FLAG_P   = 8'h04;
    localparam logic [7:0] FLAG_N   = 8'h02;
    localparam logic [7:0] FLAG_C   = 8'h01;
    localparam logic [7:0] FLAG_ALL = 8'hd7;

    localparam int RANDOM_INSTRS = 850;
    // Once fewer instructions than this remain, neither side idles any more.
    localparam int CALM_TAIL     = 100;

    typedef struct packed {
        logic [7:0]  opcode;
        logic [7:0]  disp;
        logic [7:0]  mem_byte;
        logic [15:0] word_in;
        logic [7:0]  reg_byte;
        logic        hold;
    } t_instr;

    // Layout of the output tdata, highest field first.
    typedef struct packed {
        logic [1:0]  fill;
        logic [4:0]  t_states;
        logic [15:0] index;
        logic [7:0]  flags;
        logic [7:0]  acc;
        logic [7:0]  load_byte;
        logic [15:0] word_result;
        logic [7:0]  write_byte;
        logic        mem_write;
        logic [15:0] eff_address;
    } t_result_beat;

    typedef struct packed {
        t_result_beat beat;
        logic [1:0]   status;
    } t_exec_outcome;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    t_instr      cur_instr = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [87:0] m_tdata;
    logic [1:0]  m_tuser;

    t_instr        instr_queue[$];
    t_exec_outcome pending_outcomes[$];

    // Architectural state as the predictor sees it.
    logic [7:0]  cpu_acc = '0;
    logic [7:0]  cpu_flags = '0;
    logic [15:0] cpu_index = '0;

    int n_accepted = 0;
    int n_checked = 0;
    int n_errors = 0;
    int n_traps = 0;
    int n_mem_writes = 0;
    int send_gap = 0;
    int recv_gap = 0;

    always #1 clk = ~clk;

    indexed_register_instruction_executor_top dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  ({cur_instr.reg_byte, cur_instr.word_in,
                           cur_instr.mem_byte, cur_instr.disp}),
        .i_s_axis_tuser  (cur_instr.opcode),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    function automatic logic [7:0] sign_zero(input logic [7:0] r);
        return (r[7] ? FLAG_S : 8'h00) | (r == 8'h00 ? FLAG_Z : 8'h00);
    endfunction

    // Returns {new flags, result}.
    function automatic logic [15:0] alu8(input logic [7:0] a, input logic [7:0] b,
                                         input logic cin, input logic sub,
                                         input logic [7:0] f);
        logic [8:0] s;
        logic [4:0] h;
        logic [7:0] nf;
        if (!sub) begin
            s = {1'b0, a} + {1'b0, b} + {8'd0, cin};
            h = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cin};
            nf = ((a[7] ^ s[7]) & (b[7] ^ s[7])) ? FLAG_P : 8'h00;
        end else begin
            // The ninth bit of a 9-bit difference is the borrow.
            s = {1'b0, a} - {1'b0, b} - {8'd0, cin};
            h = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, cin};
            nf = FLAG_N | (((a[7] ^ b[7]) & (a[7] ^ s[7])) ? FLAG_P : 8'h00);
        end
        nf = nf | (s[8] ? FLAG_C : 8'h00) | (h[4] ? FLAG_H : 8'h00) | sign_zero(s[7:0]);
        return {(f & ~FLAG_ALL) | nf, s[7:0]};
    endfunction

    // Returns {new flags, sum}.
    function automatic logic [23:0] add16(input logic [15:0] x, input logic [15:0] y,
                                          input logic [7:0] f);
        logic [16:0] s;
        logic [12:0] h;
        s = {1'b0, x} + {1'b0, y};
        h = {1'b0, x[11:0]} + {1'b0, y[11:0]};
        return {(f & ~(FLAG_H | FLAG_N | FLAG_C)) | (h[12] ? FLAG_H : 8'h00)
                | (s[16] ? FLAG_C : 8'h00), s[15:0]};
    endfunction

    function automatic t_exec_outcome execute_instr(input t_instr it);
        t_exec_outcome e;
        logic [7:0]  a;
        logic [7:0]  f;
        logic [7:0]  r;
        logic [15:0] ix;
        logic [15:0] alu;
        logic [23:0] wide;
        e = '0;
        a = cpu_acc;
        f = cpu_flags;
        ix = cpu_index;
        e.status = irie_pkg::ST_OK;
        e.beat.eff_address = cpu_index + {{8{it.disp[7]}}, it.disp};
        case (it.opcode)
            irie_pkg::OP_ADD_IX_BC, irie_pkg::OP_ADD_IX_DE, irie_pkg::OP_ADD_IX_SP: begin
                wide = add16(ix, it.word_in, f);
                {f, ix} = wide;
                e.beat.t_states = 5'd15;
            end
            irie_pkg::OP_ADD_IX_IX: begin
                wide = add16(ix, ix, f);
                {f, ix} = wide;
                e.beat.t_states = 5'd15;
            end
            irie_pkg::OP_LD_IX_NN, irie_pkg::OP_POP_IX: begin
                ix = it.word_in;
                e.beat.t_states = 5'd14;
            end
            irie_pkg::OP_LD_IX_MNN: begin
                ix = it.word_in;
                e.beat.t_states = 5'd20;
            end
            irie_pkg::OP_ST_NN_IX: begin
                e.beat.word_result = ix;
                e.beat.t_states = 5'd20;
            end
            irie_pkg::OP_INC_IX: begin
                ix = ix + 16'd1;
                e.beat.t_states = 5'd10;
            end
            irie_pkg::OP_DEC_IX: begin
                ix = ix - 16'd1;
                e.beat.t_states = 5'd10;
            end
            irie_pkg::OP_INC_MEM: begin
                r = it.mem_byte + 8'd1;
                f = (f & ~(FLAG_S | FLAG_Z | FLAG_H | FLAG_P | FLAG_N)) | sign_zero(r)
                    | (it.mem_byte[3:0] == 4'hf ? FLAG_H : 8'h00)
                    | (r == 8'h80 ? FLAG_P : 8'h00);
                e.beat.mem_write = 1'b1;
                e.beat.write_byte = r;
                e.beat.t_states = 5'd23;
            end
            irie_pkg::OP_DEC_MEM: begin
                r = it.mem_byte - 8'd1;
                f = (f & ~(FLAG_S | FLAG_Z | FLAG_H | FLAG_P | FLAG_N)) | sign_zero(r)
                    | FLAG_N | (it.mem_byte[3:0] == 4'h0 ? FLAG_H : 8'h00)
                    | (r == 8'h7f ? FLAG_P : 8'h00);
                e.beat.mem_write = 1'b1;
                e.beat.write_byte = r;
                e.beat.t_states = 5'd23;
            end
            irie_pkg::OP_ST_MEM_N, irie_pkg::OP_ST_MEM_B, irie_pkg::OP_ST_MEM_C,
            irie_pkg::OP_ST_MEM_D, irie_pkg::OP_ST_MEM_E, irie_pkg::OP_ST_MEM_H,
            irie_pkg::OP_ST_MEM_L: begin
                e.beat.mem_write = 1'b1;
                e.beat.write_byte = it.reg_byte;
                e.beat.t_states = 5'd19;
            end
            irie_pkg::OP_ST_MEM_A: begin
                e.beat.mem_write = 1'b1;
                e.beat.write_byte = a;
                e.beat.t_states = 5'd19;
            end
            irie_pkg::OP_LD_B_MEM, irie_pkg::OP_LD_C_MEM, irie_pkg::OP_LD_D_MEM,
            irie_pkg::OP_LD_E_MEM, irie_pkg::OP_LD_H_MEM, irie_pkg::OP_LD_L_MEM: begin
                e.beat.load_byte = it.mem_byte;
                e.beat.t_states = 5'd19;
            end
            irie_pkg::OP_LD_A_MEM: begin
                e.beat.load_byte = it.mem_byte;
                a = it.mem_byte;
                e.beat.t_states = 5'd19;
            end
            irie_pkg::OP_ADD_A_MEM, irie_pkg::OP_ADC_A_MEM, irie_pkg::OP_SUB_A_MEM,
            irie_pkg::OP_SBC_A_MEM, irie_pkg::OP_CP_A_MEM: begin
                alu = alu8(a, it.mem_byte,
                           (it.opcode == irie_pkg::OP_ADC_A_MEM
                            || it.opcode == irie_pkg::OP_SBC_A_MEM) ? f[0] : 1'b0,
                           it.opcode != irie_pkg::OP_ADD_A_MEM
                           && it.opcode != irie_pkg::OP_ADC_A_MEM, f);
                f = alu[15:8];
                // Compare only sets the flags.
                if (it.opcode != irie_pkg::OP_CP_A_MEM) begin
                    a = alu[7:0];
                end
                e.beat.t_states = 5'd19;
            end
            irie_pkg::OP_AND_A_MEM, irie_pkg::OP_XOR_A_MEM, irie_pkg::OP_OR_A_MEM: begin
                if (it.opcode == irie_pkg::OP_AND_A_MEM) begin
                    a = a & it.mem_byte;
                end else if (it.opcode == irie_pkg::OP_XOR_A_MEM) begin
                    a = a ^ it.mem_byte;
                end else begin
                    a = a | it.mem_byte;
                end
                f = (f & ~FLAG_ALL) | sign_zero(a) | (~^a ? FLAG_P : 8'h00)
                    | (it.opcode == irie_pkg::OP_AND_A_MEM ? FLAG_H : 8'h00);
                e.beat.t_states = 5'd19;
            end
            irie_pkg::OP_PUSH_IX: begin
                e.beat.word_result = ix;
                e.beat.t_states = 5'd15;
            end
            irie_pkg::OP_EX_SP_IX: begin
                e.beat.word_result = ix;
                ix = it.word_in;
                e.beat.t_states = 5'd23;
            end
            irie_pkg::OP_JP_IX: begin
                e.beat.word_result = ix;
                e.beat.t_states = 5'd8;
            end
            irie_pkg::OP_LD_SP_IX: begin
                e.beat.word_result = ix;
                e.beat.t_states = 5'd10;
            end
            irie_pkg::OP_BIT_ESC: e.status = irie_pkg::ST_ESCAPE;
            default:              e.status = irie_pkg::ST_ILLEGAL;
        endcase
        if (e.status != irie_pkg::ST_OK) begin
            // A trap reports the untouched state and nothing else.
            e.beat = '0;
            a = cpu_acc;
            f = cpu_flags;
            ix = cpu_index;
        end else begin
            cpu_acc = a;
            cpu_flags = f;
            cpu_index = ix;
        end
        e.beat.acc = a;
        e.beat.flags = f;
        e.beat.index = ix;
        return e;
    endfunction

    function automatic logic [7:0] random_opcode();
        logic [7:0] alu_ops[10];
        logic [7:0] all_ops[39];
        alu_ops = '{irie_pkg::OP_ADD_A_MEM, irie_pkg::OP_ADC_A_MEM, irie_pkg::OP_SUB_A_MEM,
                    irie_pkg::OP_SBC_A_MEM, irie_pkg::OP_AND_A_MEM, irie_pkg::OP_XOR_A_MEM,
                    irie_pkg::OP_OR_A_MEM, irie_pkg::OP_CP_A_MEM, irie_pkg::OP_INC_MEM,
                    irie_pkg::OP_DEC_MEM};
        all_ops = '{irie_pkg::OP_ADD_IX_BC, irie_pkg::OP_ADD_IX_DE, irie_pkg::OP_LD_IX_NN,
                    irie_pkg::OP_ST_NN_IX, irie_pkg::OP_INC_IX, irie_pkg::OP_ADD_IX_IX,
                    irie_pkg::OP_LD_IX_MNN, irie_pkg::OP_DEC_IX, irie_pkg::OP_INC_MEM,
                    irie_pkg::OP_DEC_MEM, irie_pkg::OP_ST_MEM_N, irie_pkg::OP_ADD_IX_SP,
                    irie_pkg::OP_LD_B_MEM, irie_pkg::OP_LD_C_MEM, irie_pkg::OP_LD_D_MEM,
                    irie_pkg::OP_LD_E_MEM, irie_pkg::OP_LD_H_MEM, irie_pkg::OP_LD_L_MEM,
                    irie_pkg::OP_ST_MEM_B, irie_pkg::OP_ST_MEM_C, irie_pkg::OP_ST_MEM_D,
                    irie_pkg::OP_ST_MEM_E, irie_pkg::OP_ST_MEM_H, irie_pkg::OP_ST_MEM_L,
                    irie_pkg::OP_ST_MEM_A, irie_pkg::OP_LD_A_MEM, irie_pkg::OP_ADD_A_MEM,
                    irie_pkg::OP_ADC_A_MEM, irie_pkg::OP_SUB_A_MEM, irie_pkg::OP_SBC_A_MEM,
                    irie_pkg::OP_AND_A_MEM, irie_pkg::OP_XOR_A_MEM, irie_pkg::OP_OR_A_MEM,
                    irie_pkg::OP_CP_A_MEM, irie_pkg::OP_POP_IX, irie_pkg::OP_EX_SP_IX,
                    irie_pkg::OP_PUSH_IX, irie_pkg::OP_JP_IX, irie_pkg::OP_LD_SP_IX};
        // Flag-producing byte operations get extra weight.
        if ($urandom_range(0, 2) == 0) begin
            return alu_ops[$urandom_range(0, 9)];
        end
        return all_ops[$urandom_range(0, 38)];
    endfunction

    function automatic t_instr random_instr();
        t_instr      it;
        int          pick;
        logic [7:0]  byte_corners[8];
        logic [15:0] word_corners[6];
        byte_corners = '{8'h00, 8'h01, 8'h0f, 8'h10, 8'h7f, 8'h80, 8'hf0, 8'hff};
        word_corners = '{16'h0000, 16'h0001, 16'h0fff, 16'h8000, 16'hf001, 16'hffff};
        it = '0;
        pick = $urandom_range(0, 99);
        if (pick < 88) begin
            it.opcode = random_opcode();
        end else if (pick < 97) begin
            it.opcode = 8'($urandom_range(0, 255));
        end else begin
            it.opcode = irie_pkg::OP_BIT_ESC;
        end
        it.disp = 8'($urandom_range(0, 255));
        it.mem_byte = ($urandom_range(0, 3) == 0) ? byte_corners[$urandom_range(0, 7)]
                                                  : 8'($urandom_range(0, 255));
        it.word_in = ($urandom_range(0, 4) == 0) ? word_corners[$urandom_range(0, 5)]
                                                 : 16'($urandom_range(0, 65535));
        it.reg_byte = 8'($urandom_range(0, 255));
        return it;
    endfunction

    task automatic add_instr(input logic [7:0] opcode, input logic [7:0] disp,
                             input logic [7:0] mem_byte, input logic [15:0] word_in,
                             input logic [7:0] reg_byte);
        instr_queue.push_back('{opcode, disp, mem_byte, word_in, reg_byte, 1'b0});
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            n_errors++;
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
        end
    endtask

    function automatic bit idling_allowed(input int remaining, input int done);
        // Every third block of 64 transfers runs without idling.
        return remaining >= CALM_TAIL && (done / 64) % 3 != 2;
    endfunction

    // Sender: the item on the bus is the one predicted at its transfer.
    always @(posedge clk) begin
        logic   next_valid;
        t_instr next_item;
        next_valid = s_valid;
        next_item = cur_instr;
        if (!rst_n) begin
            next_valid = 1'b0;
            send_gap = 0;
        end else begin
            if (s_valid && s_ready) begin
                pending_outcomes.push_back(execute_instr(cur_instr));
                n_accepted++;
                next_valid = 1'b0;
            end
            if (!next_valid && instr_queue.size() != 0) begin
                if (send_gap != 0) begin
                    send_gap--;
                end else if (instr_queue[0].hold && pending_outcomes.size() != 0) begin
                    // Let the block drain completely before going on.
                end else if (idling_allowed(instr_queue.size(), n_accepted)
                             && $urandom_range(0, 4) == 0) begin
                    send_gap = $urandom_range(0, 9);
                end else begin
                    next_item = instr_queue.pop_front();
                    next_valid = 1'b1;
                end
            end
        end
        s_valid <= next_valid;
        cur_instr <= next_item;
    end

    // Receiver back-pressure.
    always @(posedge clk) begin
        logic next_ready;
        if (!rst_n) begin
            next_ready = 1'b1;
            recv_gap = 0;
        end else if (recv_gap != 0) begin
            recv_gap--;
            next_ready = 1'b0;
        end else if (idling_allowed(instr_queue.size(), n_checked)
                     && $urandom_range(0, 4) == 0) begin
            recv_gap = $urandom_range(0, 9);
            next_ready = 1'b0;
        end else begin
            next_ready = 1'b1;
        end
        m_ready <= next_ready;
    end

    // Output monitor.
    always @(posedge clk) begin
        t_exec_outcome want;
        t_result_beat  got;
        if (rst_n && m_valid && m_ready) begin
            got = t_result_beat'(m_tdata);
            if (pending_outcomes.size() == 0) begin
                n_errors++;
                $display("%0t: result transfer with nothing expected, tdata 0x%0h", $time,
                         m_tdata);
            end else begin
                want = pending_outcomes.pop_front();
                n_checked++;
                if (want.status != irie_pkg::ST_OK) n_traps++;
                if (want.beat.mem_write) n_mem_writes++;
                check_field("eff_address", want.beat.eff_address, got.eff_address);
                check_field("mem_write", 16'(want.beat.mem_write), 16'(got.mem_write));
                check_field("write_byte", 16'(want.beat.write_byte), 16'(got.write_byte));
                check_field("word_result", want.beat.word_result, got.word_result);
                check_field("load_byte", 16'(want.beat.load_byte), 16'(got.load_byte));
                check_field("acc", 16'(want.beat.acc), 16'(got.acc));
                check_field("flags", 16'(want.beat.flags), 16'(got.flags));
                check_field("index", want.beat.index, got.index);
                check_field("t_states", 16'(want.beat.t_states), 16'(got.t_states));
                check_field("status", 16'(want.status), 16'(m_tuser));
            end
        end
    end

    initial begin
        t_instr it;
        // Index adds with carries out of bits 11 and 15.
        add_instr(irie_pkg::OP_LD_IX_NN, 8'h00, 8'h00, 16'hffff, 8'h00);
        add_instr(irie_pkg::OP_ADD_IX_BC, 8'h00, 8'h00, 16'h0001, 8'h00);
        add_instr(irie_pkg::OP_LD_IX_NN, 8'h00, 8'h00, 16'h0fff, 8'h00);
        add_instr(irie_pkg::OP_ADD_IX_DE, 8'h00, 8'h00, 16'h0001, 8'h00);
        add_instr(irie_pkg::OP_ADD_IX_IX, 8'h00, 8'h00, 16'h0000, 8'h00);
        add_instr(irie_pkg::OP_LD_IX_MNN, 8'h00, 8'h00, 16'h8000, 8'h00);
        add_instr(irie_pkg::OP_INC_IX, 8'h80, 8'h00, 16'h0000, 8'h00);
        add_instr(irie_pkg::OP_DEC_IX, 8'h7f, 8'h00, 16'h0000, 8'h00);
        // Byte arithmetic across both displacement extremes and overflow.
        add_instr(irie_pkg::OP_LD_A_MEM, 8'h80, 8'h7f, 16'h0000, 8'h00);
        add_instr(irie_pkg::OP_ADD_A_MEM, 8'h7f, 8'h01, 16'h0000, 8'h00);
        add_instr(irie_pkg::OP_ADC_A_MEM, 8'h00, 8'hff, 16'h0000, 8'h00);
        add_instr(irie_pkg::OP_SBC_A_MEM, 8'h01, 8'h00, 16'h0000, 8'h00);
        add_instr(irie_pkg::OP_SUB_A_MEM, 8'hff, 8'hff, 16'h0000, 8'h00);
        add_instr(irie_pkg::OP_CP_A_MEM, 8'h10, 8'h80, 16'h0000, 8'h00);
        add_instr(irie_pkg::OP_AND_A_MEM, 8'h00, 8'hff, 16'h0000, 8'h00);
        add_instr(irie_pkg::OP_XOR_A_MEM, 8'h00, 8'hff, 16'h0000, 8'h00);
        add_instr(irie_pkg::OP_OR_A_MEM, 8'h00, 8'h00, 16'h0000, 8'h00);
        add_instr(irie_pkg::OP_INC_MEM, 8'h05, 8'h7f, 16'h0000, 8'h00);
        add_instr(irie_pkg::OP_DEC_MEM, 8'hfb, 8'h80, 16'h0000, 8'h00);
        add_instr(irie_pkg::OP_ST_MEM_N, 8'h00, 8'h00, 16'hffff, 8'hff);
        add_instr(irie_pkg::OP_ST_MEM_A, 8'h00, 8'h00, 16'h0000, 8'h00);
        add_instr(irie_pkg::OP_LD_B_MEM, 8'h00, 8'haa, 16'h0000, 8'h00);
        add_instr(irie_pkg::OP_EX_SP_IX, 8'h00, 8'h00, 16'hffff, 8'h00);
        add_instr(irie_pkg::OP_PUSH_IX, 8'h00, 8'h00, 16'h0000, 8'h00);
        add_instr(irie_pkg::OP_BIT_ESC, 8'h7f, 8'hff, 16'hffff, 8'hff);
        add_instr(8'hff, 8'h80, 8'hff, 16'hffff, 8'hff);
        for (int i = 0; i < RANDOM_INSTRS; i++) begin
            it = random_instr();
            it.hold = (i == 250 || i == 600);
            instr_queue.push_back(it);
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (instr_queue.size() != 0 || s_valid) @(posedge clk);
        while (pending_outcomes.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Executed %0d instructions, %0d results checked, %0d errors.",
                 n_accepted, n_checked, n_errors);
        $display("Among them %0d trapped opcodes and %0d indexed memory writes.",
                 n_traps, n_mem_writes);
        if (n_errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #500000;
        $display("Timed out with %0d results still outstanding.", pending_outcomes.size());
        $display("status: fail");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/irie_pkg.sv
rtl/irie_exec.sv
rtl/indexed_register_instruction_executor_top.sv
bench/tb.sv
